// ===== rtl/tdq_pkg.sv =====
package tdq_pkg;

  // Register map, word index on the configuration port
  typedef enum logic [2:0] {
    REG_FMT       = 3'd0,
    REG_QSCHEME   = 3'd1,
    REG_FIXED_POS = 3'd2,
    REG_ZPOINT    = 3'd3,
    REG_SCALE     = 3'd4
  } reg_idx_t;

  // Element formats
  localparam logic [2:0] FMT_FP32  = 3'd0;
  localparam logic [2:0] FMT_FP16  = 3'd1;
  localparam logic [2:0] FMT_UINT8 = 3'd2;
  localparam logic [2:0] FMT_INT8  = 3'd3;
  localparam logic [2:0] FMT_INT16 = 3'd4;

  // Int8 quantization schemes
  localparam logic [1:0] QF_FIXED  = 2'd0;
  localparam logic [1:0] QF_AFFINE = 2'd1;

  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
  localparam logic [31:0] FP32_QNAN   = 32'h7FC0_0000;
  localparam logic [31:0] FP32_QUIET  = 32'h0040_0000;
  localparam logic [7:0]  EXP_MAX     = 8'hFF;
  localparam logic [23:0] SIG_ONE     = 24'h80_0000;
  localparam int          POS_LIMIT   = 30;

  typedef struct packed {
    logic [2:0]        fmt;
    logic [1:0]        qscheme;
    logic signed [5:0] frac_pos;
    logic signed [8:0] zpoint;
    logic [31:0]       scale;
  } cfg_t;

  // Decoded element: either a finished value or a multiply request
  typedef struct packed {
    logic        err;
    logic        use_mul;
    logic [31:0] pass_val;
    logic        neg;
    logic [15:0] mag;
    logic [23:0] sig;
    logic [7:0]  expo;
  } front_t;

  // Fields that ride along the multiply stages unchanged
  typedef struct packed {
    logic        last;
    logic        err;
    logic        use_mul;
    logic [31:0] pass_val;
    logic        neg;
  } side_t;

endpackage

// ===== rtl/tdq_cfg.sv =====
module tdq_cfg
  import tdq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fmt      <= FMT_FP32;
      cfg.qscheme  <= QF_FIXED;
      cfg.frac_pos <= '0;
      cfg.zpoint   <= '0;
      cfg.scale    <= SCALE_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_FMT:       cfg.fmt      <= pwdata[2:0];
        REG_QSCHEME:   cfg.qscheme  <= pwdata[1:0];
        REG_FIXED_POS: cfg.frac_pos <= $signed(pwdata[5:0]);
        REG_ZPOINT:    cfg.zpoint   <= $signed(pwdata[8:0]);
        REG_SCALE:     cfg.scale    <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back raw register bits
  always_comb begin
    unique case (idx)
      REG_FMT:       prdata = {29'd0, cfg.fmt};
      REG_QSCHEME:   prdata = {30'd0, cfg.qscheme};
      REG_FIXED_POS: prdata = {26'd0, cfg.frac_pos};
      REG_ZPOINT:    prdata = {23'd0, cfg.zpoint};
      REG_SCALE:     prdata = cfg.scale;
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/tdq_front.sv =====
module tdq_front
  import tdq_pkg::*;
(
  input  cfg_t        cfg,
  input  logic [31:0] raw_word,
  output front_t      front
);

  logic signed [16:0] ival;
  logic signed [17:0] dval;
  logic               affine;
  logic               fixed;
  logic               err;
  logic [17:0]        dabs;
  logic signed [5:0]  pos;
  logic [7:0]         sexp;
  logic [22:0]        sfrac;
  logic               sneg;
  logic [31:0]        h16;
  logic [3:0]         lead;
  logic [9:0]         hsub;

  // Pick the integer view and the conversion for the format
  always_comb begin
    ival   = '0;
    affine = 1'b0;
    fixed  = 1'b0;
    err    = 1'b0;
    case (cfg.fmt)
      FMT_FP32, FMT_FP16: ;
      FMT_UINT8: begin
        ival   = {9'd0, raw_word[7:0]};
        affine = 1'b1;
      end
      FMT_INT8: begin
        ival = {{9{raw_word[7]}}, raw_word[7:0]};
        if (cfg.qscheme == QF_FIXED)       fixed  = 1'b1;
        else if (cfg.qscheme == QF_AFFINE) affine = 1'b1;
        else                               err    = 1'b1;
      end
      FMT_INT16: begin
        ival  = {raw_word[15], raw_word[15:0]};
        fixed = 1'b1;
      end
      default: err = 1'b1;
    endcase
  end

  assign dval = affine ? ({ival[16], ival} - 18'(cfg.zpoint))
                       : {ival[16], ival};
  assign dabs = dval[17] ? 18'(-dval) : dval;

  // Saturate the fraction position and form the power of two scale
  always_comb begin
    if (cfg.frac_pos > 6'(POS_LIMIT))       pos = 6'(POS_LIMIT);
    else if (cfg.frac_pos < -6'(POS_LIMIT)) pos = -6'(POS_LIMIT);
    else                                    pos = cfg.frac_pos;
  end

  assign sexp  = cfg.scale[30:23];
  assign sfrac = cfg.scale[22:0];
  assign sneg  = dval[17] ^ (affine & cfg.scale[31]);

  // Widen half precision, normalizing subnormals
  always_comb begin
    lead = '0;
    for (int i = 0; i < 10; i++) begin
      if (raw_word[i]) lead = 4'(i);
    end
    hsub = raw_word[9:0] << (4'd10 - lead);
    if (raw_word[14:10] == 5'h1F)
      h16 = {raw_word[15], EXP_MAX, raw_word[9:0], 13'd0};
    else if (raw_word[14:10] != 5'd0)
      h16 = {raw_word[15], 8'(raw_word[14:10]) + 8'd112, raw_word[9:0], 13'd0};
    else if (raw_word[9:0] == 10'd0)
      h16 = {raw_word[15], 31'd0};
    else
      h16 = {raw_word[15], 8'd103 + 8'(lead), hsub, 13'd0};
  end

  // Settle special cases here, hand the rest to the multiplier
  always_comb begin
    front.err      = err;
    front.use_mul  = 1'b0;
    front.pass_val = '0;
    front.neg      = sneg;
    front.mag      = dabs[15:0];
    front.sig      = SIG_ONE;
    front.expo     = 8'(8'sd127 - 8'(pos));
    if (affine) begin
      front.sig  = {(sexp != 8'd0), sfrac};
      front.expo = (sexp == 8'd0) ? 8'd1 : sexp;
    end
    if (cfg.fmt == FMT_FP32) begin
      front.pass_val = raw_word;
    end else if (cfg.fmt == FMT_FP16) begin
      front.pass_val = h16;
    end else if (affine && sexp == EXP_MAX) begin
      if (sfrac != 23'd0)      front.pass_val = cfg.scale | FP32_QUIET;
      else if (dabs == 18'd0)  front.pass_val = FP32_QNAN;
      else                     front.pass_val = {sneg, EXP_MAX, 23'd0};
    end else if (dabs == 18'd0 || (affine && cfg.scale[30:0] == 31'd0)) begin
      front.pass_val = {sneg, 31'd0};
    end else if (affine || fixed) begin
      front.use_mul = 1'b1;
    end
  end

endmodule

// ===== rtl/tdq_pipe.sv =====
module tdq_pipe
  import tdq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  front_t      front,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value_bits,
  output logic        status,
  output logic        last_out
);

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4, r5;

  front_t       f1;
  logic         last1;
  side_t        sd2, sd3, sd4;
  logic [39:0]  prod2, prod3;
  logic [7:0]   expo2;
  logic [5:0]   shamt3, shamt_next;
  logic [7:0]   expf3, expf4, expf_next;
  logic         inf3, inf4, inf_next;
  logic [22:0]  mant4;
  logic         g4, st4;
  logic [5:0]   lead;
  logic signed [9:0] er;
  logic [39:0]  norm;
  logic         rnd;
  logic [30:0]  body;

  // Ready chain: a stage takes a request when empty or draining
  assign r5       = !out_valid || out_ready;
  assign r4       = !v4 || r5;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  // Stage 1: hold the decoded element
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (r1) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      f1    <= front;
      last1 <= in_last;
    end
  end

  // Stage 2: integer magnitude times significand
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (r2) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      prod2 <= f1.mag * f1.sig;
      expo2 <= f1.expo;
      sd2   <= '{last: last1, err: f1.err, use_mul: f1.use_mul,
                 pass_val: f1.pass_val, neg: f1.neg};
    end
  end

  // Stage 3: find the leading one and plan the shift
  always_comb begin
    lead = '0;
    for (int i = 0; i < 40; i++) begin
      if (prod2[i]) lead = 6'(i);
    end
    er = $signed({4'd0, lead}) + $signed({2'd0, expo2}) - 10'sd23;
    inf_next = 1'b0;
    if (er >= 10'sd255) begin
      inf_next   = 1'b1;
      shamt_next = '0;
      expf_next  = '0;
    end else if (er >= 10'sd1) begin
      shamt_next = 6'd39 - lead;
      expf_next  = er[7:0];
    end else begin
      // result is subnormal and exact
      shamt_next = 6'(expo2 + 8'd15);
      expf_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (r3) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      prod3  <= prod2;
      shamt3 <= shamt_next;
      expf3  <= expf_next;
      inf3   <= inf_next;
      sd3    <= sd2;
    end
  end

  // Stage 4: normalize and split off guard and sticky
  assign norm = prod3 << shamt3;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (r4) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (r4 && v3) begin
      mant4 <= norm[38:16];
      g4    <= norm[15];
      st4   <= |norm[14:0];
      expf4 <= expf3;
      inf4  <= inf3;
      sd4   <= sd3;
    end
  end

  // Stage 5: round to nearest even, pack, select the result
  assign rnd  = g4 & (st4 | mant4[0]);
  assign body = {expf4, mant4} + 31'(rnd);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (r5) out_valid <= v4;
  end
  always_ff @(posedge clk) begin
    if (r5 && v4) begin
      status   <= sd4.err;
      last_out <= sd4.last;
      if (sd4.err)          value_bits <= '0;
      else if (!sd4.use_mul) value_bits <= sd4.pass_val;
      else if (inf4)        value_bits <= {sd4.neg, EXP_MAX, 23'd0};
      else                  value_bits <= {sd4.neg, body};
    end
  end

endmodule

// ===== rtl/tensor_dequant_to_fp32_top.sv =====
// Tensor element dequantizer to IEEE single precision.
// Input stream: s_tdata carries one raw element (low 8, 16 or 32 bits used),
// s_tlast marks the final element of a tensor. Output stream: m_tdata is the
// fp32 bit pattern, m_tuser is the status flag (1 = unsupported format or
// int8 scheme, data zero), m_tlast copies the input tlast.
// Format, quantization scheme, fraction position, zero point and scale are
// set through the APB port; the user must see that they are changed only
// while the stream is idle; the block itself does not enforce this. Throughput
// is one element per cycle while the receiver does not stall. After the
// input register the depth is set by the 16x24 multiply, a 40-bit
// leading-one search, normalize shift and round, one stage each; m_tvalid
// rises when an accepted request leaves the round stage. Reset clears all
// stage valid bits and loads the default registers (fp32 pass-through,
// scale 1.0). When the receiver stalls, the pipeline keeps filling its
// empty stages and only then drops s_tready; no request is lost or repeated.
module tensor_dequant_to_fp32_top
  import tdq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // raw_word
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // value_bits
  output logic        m_tuser,   // status
  output logic        m_tlast    // last_out
);

  cfg_t   cfg;
  front_t front;

  tdq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tdq_front u_front (
    .cfg      (cfg),
    .raw_word (s_tdata),
    .front    (front)
  );

  tdq_pipe u_pipe (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .front      (front),
    .in_last    (s_tlast),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .value_bits (m_tdata),
    .status     (m_tuser),
    .last_out   (m_tlast)
  );

endmodule

// ===== tb/tb_tensor_dequant_to_fp32_top.sv =====
module tb_tensor_dequant_to_fp32_top;
  import tdq_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // raw_word
  logic        s_tlast = 1'b0; // last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // value_bits
  logic        m_tuser;        // status
  logic        m_tlast;        // last_out

  tensor_dequant_to_fp32_top u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct {
    logic [31:0] value_bits;
    logic        status;
    logic        last_out;
  } fp32_result_t;

  // Expected fp32 results, worked out from the mirrored register settings
  class dequant_scoreboard;
    logic [2:0]        fmt = FMT_FP32;
    logic [1:0]        qscheme = QF_FIXED;
    logic signed [5:0] frac_pos = '0;
    logic signed [8:0] zpoint = '0;
    logic [31:0]       scale = SCALE_RESET;
    fp32_result_t      pending[$];
    int                errors = 0;
    int                checked = 0;

    function void report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    endfunction

    function logic [31:0] widen_half(logic [15:0] h);
      logic [9:0] m;
      int k;
      m = h[9:0];
      k = 0;
      if (h[14:10] == 5'd31) return {h[15], 8'hFF, m, 13'b0};
      if (h[14:10] != 5'd0) return {h[15], 8'(h[14:10] + 8'd112), m, 13'b0};
      if (m == 0) return {h[15], 31'b0};
      while (m[9] == 1'b0) begin
        m = m << 1;
        k++;
      end
      // leading one drops off, one more step normalizes
      return {h[15], 8'(112 - k), m[8:0], 14'b0};
    endfunction

    // Integer magnitude times fp32, rounded once to nearest even
    function logic [31:0] mul_int_fp32(logic neg, logic [15:0] mag, logic [31:0] s);
      logic [63:0] prod, q, rem, half, total;
      logic [23:0] sig;
      logic        sgn;
      int          n, x2, ebias, sh;
      sgn = s[31] ^ neg;
      if (s[30:23] == EXP_MAX) return {sgn, EXP_MAX, 23'b0};
      sig = (s[30:23] == 0) ? {1'b0, s[22:0]} : {1'b1, s[22:0]};
      x2 = (s[30:23] == 0) ? -149 : int'(s[30:23]) - 150;
      prod = 64'(mag) * 64'(sig);
      if (prod == 0) return {sgn, 31'b0};
      n = 0;
      for (int i = 0; i < 64; i++) if (prod[i]) n = i;
      ebias = n + x2 + 127;
      if (ebias >= 1) begin
        sh = n - 23;
        total = 64'(ebias - 1) << 23;
      end else begin
        sh = -(x2 + 149);
        total = 0;
      end
      if (sh <= 0) begin
        q = prod << (-sh);
      end else begin
        if (sh > 63) sh = 63;
        q = prod >> sh;
        rem = prod - (q << sh);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q++;
      end
      total = total + q;
      if (total >= 64'h7F80_0000) total = 64'h7F80_0000;
      return {sgn, total[30:0]};
    endfunction

    function logic [31:0] fixed_val(int v);
      int p;
      p = frac_pos;
      if (p > POS_LIMIT) p = POS_LIMIT;
      if (p < -POS_LIMIT) p = -POS_LIMIT;
      return mul_int_fp32(v < 0, 16'(v < 0 ? -v : v), 32'(127 - p) << 23);
    endfunction

    function logic [31:0] affine_val(int v);
      int d;
      d = v - int'(zpoint);
      if (scale[30:23] == EXP_MAX) begin
        if (scale[22:0] != 0) return scale | FP32_QUIET;
        if (d == 0) return FP32_QNAN;
      end
      return mul_int_fp32(d < 0, 16'(d < 0 ? -d : d), scale);
    endfunction

    function void note_request(logic [31:0] raw, logic last);
      fp32_result_t r;
      r.value_bits = '0;
      r.status = 1'b0;
      r.last_out = last;
      case (fmt)
        FMT_FP32:  r.value_bits = raw;
        FMT_FP16:  r.value_bits = widen_half(raw[15:0]);
        FMT_UINT8: r.value_bits = affine_val(int'(raw[7:0]));
        FMT_INT8: begin
          if (qscheme == QF_FIXED) r.value_bits = fixed_val(int'($signed(raw[7:0])));
          else if (qscheme == QF_AFFINE)
            r.value_bits = affine_val(int'($signed(raw[7:0])));
          else r.status = 1'b1;
        end
        FMT_INT16: r.value_bits = fixed_val(int'($signed(raw[15:0])));
        default:   r.status = 1'b1;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] data, logic user, logic last);
      fp32_result_t r;
      if (pending.size() == 0) begin
        report("unexpected result", data, 0);
        return;
      end
      r = pending.pop_front();
      checked++;
      if (data !== r.value_bits) report("value_bits", data, r.value_bits);
      if (user !== r.status) report("status", 32'(user), 32'(r.status));
      if (last !== r.last_out) report("last_out", 32'(last), 32'(r.last_out));
    endfunction
  endclass

  dequant_scoreboard sb = new();
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_cnt = 0;
  int sent = 0;

  // Check results and watch for a hang
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    if (!rst && !(m_tvalid && m_tready) && !(s_tvalid && s_tready)) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= 5000) begin
      $display("watchdog expired, %0d results outstanding", sb.pending.size());
      $display("[tensor_dequant_to_fp32_top] ERROR");
      $finish;
    end
  end

  // Receiver stall pattern: none, periodic, or random
  always @(negedge clk) begin
    stall_cnt++;
    case (stall_mode)
      0: m_tready = 1'b1;
      1: m_tready = (stall_cnt % 7) < 4;
      2: m_tready = (stall_cnt % 23) > 15;
      default: m_tready = ($urandom_range(0, 3) != 0);
    endcase
  end

  task reg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = 5'(idx) << 2;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_FMT:       sb.fmt = val[2:0];
      REG_QSCHEME:   sb.qscheme = val[1:0];
      REG_FIXED_POS: sb.frac_pos = val[5:0];
      REG_ZPOINT:    sb.zpoint = val[8:0];
      default:       sb.scale = val;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Hold until every result is back, then let the pipe drain
  task drain;
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task set_format(logic [2:0] df, logic [1:0] qf, logic [5:0] pos, logic [8:0] zp,
                  logic [31:0] sc);
    drain();
    reg_write(REG_FMT, 32'(df));
    reg_write(REG_QSCHEME, 32'(qf));
    reg_write(REG_FIXED_POS, 32'(pos));
    reg_write(REG_ZPOINT, 32'(zp));
    reg_write(REG_SCALE, sc);
  endtask

  // Present one request at the falling edge and wait for acceptance
  task send(logic [31:0] raw, logic last);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = raw;
    s_tlast = last;
    do @(posedge clk); while (!s_tready);
    sb.note_request(raw, last);
    sent++;
  endtask

  task gap(int n);
    @(negedge clk);
    s_tvalid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function logic [31:0] pick_scale();
    case ($urandom_range(0, 9))
      0: return 32'h7F80_0000 | (32'($urandom_range(0, 1)) << 31);
      1: return 32'h7F80_0000 | 32'($urandom_range(1, 32'h7F_FFFF));
      2: return 32'($urandom_range(0, 32'h7F_FFFF)) | (32'($urandom_range(0, 1)) << 31);
      3: return 32'h7F00_0000 | 32'($urandom_range(0, 32'hFF_FFFF));
      4: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function logic [31:0] pick_raw(logic [2:0] df);
    logic [31:0] r;
    r = $urandom();
    if (df == FMT_FP16 && $urandom_range(0, 3) == 0)
      r[14:10] = ($urandom_range(0, 1) != 0) ? 5'd31 : 5'd0;
    return r;
  endfunction

  initial begin
    logic [2:0] df;
    int burst;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset defaults pass fp32 through
    send(32'h0000_0000, 1'b0);
    send(32'hFFFF_FFFF, 1'b1);
    send(32'h7FC0_0001, 1'b0);
    // fp16 zero, subnormal, max, negative infinity, NaN, unused upper bits
    set_format(FMT_FP16, 2'd3, 6'd0, 9'd0, SCALE_RESET);
    send(32'h0000_8000, 1'b0);
    send(32'h0000_0001, 1'b0);
    send(32'hABCD_03FF, 1'b0);
    send(32'h0000_7BFF, 1'b0);
    send(32'h0000_FC00, 1'b0);
    send(32'h0000_7E01, 1'b1);
    // int16 fixed point at the shift extremes and past them
    set_format(FMT_INT16, 2'd2, 6'd30, 9'd0, SCALE_RESET);
    send(32'h0000_8000, 1'b0);
    send(32'hFFFF_7FFF, 1'b0);
    set_format(FMT_INT16, 2'd1, 6'b100000, 9'd0, SCALE_RESET);
    send(32'h0000_8000, 1'b0);
    send(32'h0000_0001, 1'b1);
    // uint8 affine ignores the scheme; infinite scale times zero
    set_format(FMT_UINT8, 2'd0, 6'd31, 9'd255, 32'h7F80_0000);
    send(32'h0000_00FF, 1'b0);
    send(32'h0000_0000, 1'b0);
    set_format(FMT_UINT8, 2'd3, 6'd0, 9'h180, 32'hFF80_0001);
    send(32'h0000_0080, 1'b0);
    // int8 affine with huge and tiny scales
    set_format(FMT_INT8, QF_AFFINE, 6'd0, 9'h080, 32'h7F7F_FFFF);
    send(32'h0000_0080, 1'b0);
    send(32'h0000_007F, 1'b0);
    set_format(FMT_INT8, QF_AFFINE, 6'd0, 9'd1, 32'h0000_0003);
    send(32'h0000_00FF, 1'b0);
    // int8 unsupported schemes and unknown formats
    set_format(FMT_INT8, 2'd2, 6'd0, 9'd0, SCALE_RESET);
    send(32'h0000_0012, 1'b1);
    set_format(3'd7, 2'd0, 6'd0, 9'd0, SCALE_RESET);
    send(32'h1234_5678, 1'b0);

    // Random phases: fresh settings, bursty sender, changing receiver
    while (sent < 1000) begin
      df = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      set_format(df, 2'($urandom_range(0, 3)), 6'($urandom()), 9'($urandom()),
                 pick_scale());
      stall_mode = $urandom_range(0, 3);
      repeat ($urandom_range(4, 12)) begin
        burst = $urandom_range(1, 12);
        repeat (burst) send(pick_raw(df), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 2) != 0) gap($urandom_range(0, 5));
      end
    end

    drain();
    $display("covered %0d requests over all formats, quant schemes, special scales;", sent);
    $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) $display("[tensor_dequant_to_fp32_top] OK");
    else $display("[tensor_dequant_to_fp32_top] ERROR");
    $finish;
  end

endmodule
